// File: hw/rtl/table_driven_lexer_unit_assert.svh
// assertion macros for the lexer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef TABLE_DRIVEN_LEXER_UNIT_ASSERT_SVH
`define TABLE_DRIVEN_LEXER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TDL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tdl_pkg.sv
// shared types, codes and character tables of the table driven lexer
// no dependencies
package tdl_pkg;

  localparam int DEF_MAX_TOKEN_LENGTH = 255;
  localparam int NUM_KW = 14;
  localparam int QDEPTH = 4;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  localparam logic [2:0] CLS_KEYWORD = 3'd0;
  localparam logic [2:0] CLS_IDENT   = 3'd1;
  localparam logic [2:0] CLS_INT     = 3'd2;
  localparam logic [2:0] CLS_FLOAT   = 3'd3;
  localparam logic [2:0] CLS_INVALID = 3'd4;
  localparam logic [2:0] CLS_OP      = 3'd5;
  localparam logic [2:0] CLS_SEP     = 3'd6;

  localparam logic [1:0] SPEC_NONE   = 2'd0;
  localparam logic [1:0] SPEC_DOT    = 2'd1;
  localparam logic [1:0] SPEC_DOLLAR = 2'd2;

  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_WORD    = 3'd1,
    ST_NUM     = 3'd2,
    ST_NUM_DOT = 3'd3,
    ST_COMMENT = 3'd4,
    ST_BAD     = 3'd5
  } lex_state_t;

  typedef enum logic [2:0] {
    COL_LETTER = 3'd0,
    COL_DIGIT  = 3'd1,
    COL_BANG   = 3'd2,
    COL_SEP    = 3'd3,
    COL_DOT    = 3'd4,
    COL_OP     = 3'd5,
    COL_OTHER  = 3'd6
  } col_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic [2:0] token_class;
    logic [3:0] keyword_number;
    logic [7:0] lexeme_length;
    logic [7:0] symbol;
    logic       last_of_run;
  } out_item_t;

  // one or two results caused by one input item
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } rec_t;

  typedef struct packed {
    logic avail;
    logic full;
  } q_status_t;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic col_t col_of(input logic [7:0] c);
    if (is_letter(c)) begin
      col_of = COL_LETTER;
    end else if ((c >= 8'h30 && c <= 8'h39) || c == CH_DOLLAR) begin
      col_of = COL_DIGIT;
    end else begin
      case (c)
        CH_BANG: col_of = COL_BANG;
        CH_DOT:  col_of = COL_DOT;
        // * + - = / > < %
        8'h2A, 8'h2B, 8'h2D, 8'h3D, 8'h2F, 8'h3E, 8'h3C, 8'h25: col_of = COL_OP;
        // ' ( ) { } [ ] , : ;
        8'h27, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C, 8'h3A, 8'h3B:
          col_of = COL_SEP;
        default: col_of = COL_OTHER;
      endcase
    end
  endfunction

  function automatic lex_state_t next_state(input lex_state_t s, input col_t col);
    next_state = ST_START;
    case (s)
      ST_START: begin
        case (col)
          COL_LETTER: next_state = ST_WORD;
          COL_DIGIT:  next_state = ST_NUM;
          COL_BANG:   next_state = ST_COMMENT;
          default:    next_state = ST_START;
        endcase
      end
      ST_WORD: begin
        case (col)
          COL_LETTER, COL_DIGIT: next_state = ST_WORD;
          COL_BANG:              next_state = ST_COMMENT;
          default:               next_state = ST_START;
        endcase
      end
      ST_NUM: begin
        case (col)
          COL_LETTER: next_state = ST_BAD;
          COL_DIGIT:  next_state = ST_NUM;
          COL_BANG:   next_state = ST_COMMENT;
          COL_DOT:    next_state = ST_NUM_DOT;
          default:    next_state = ST_START;
        endcase
      end
      ST_NUM_DOT: begin
        case (col)
          COL_LETTER:         next_state = ST_BAD;
          COL_DIGIT, COL_DOT: next_state = ST_NUM_DOT;
          COL_BANG:           next_state = ST_COMMENT;
          default:            next_state = ST_START;
        endcase
      end
      ST_COMMENT: begin
        case (col)
          COL_BANG: next_state = ST_START;
          default:  next_state = ST_COMMENT;
        endcase
      end
      default: next_state = ST_START;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] idx);
    case (idx)
      4'd0:    kw_len = 4'd3;
      4'd1:    kw_len = 4'd5;
      4'd2:    kw_len = 4'd4;
      4'd3:    kw_len = 4'd2;
      4'd4:    kw_len = 4'd4;
      4'd5:    kw_len = 4'd4;
      4'd6:    kw_len = 4'd2;
      4'd7:    kw_len = 4'd5;
      4'd8:    kw_len = 4'd8;
      4'd9:    kw_len = 4'd5;
      4'd10:   kw_len = 4'd3;
      4'd11:   kw_len = 4'd3;
      4'd12:   kw_len = 4'd2;
      4'd13:   kw_len = 4'd8;
      default: kw_len = 4'd0;
    endcase
  endfunction

  // keyword text, right justified: the last character sits in bits 7:0
  function automatic logic [63:0] kw_text(input logic [3:0] idx);
    case (idx)
      4'd0:    kw_text = 64'("int");
      4'd1:    kw_text = 64'("float");
      4'd2:    kw_text = 64'("bool");
      4'd3:    kw_text = 64'("if");
      4'd4:    kw_text = 64'("else");
      4'd5:    kw_text = 64'("then");
      4'd6:    kw_text = 64'("do");
      4'd7:    kw_text = 64'("while");
      4'd8:    kw_text = 64'("whileend");
      4'd9:    kw_text = 64'("doend");
      4'd10:   kw_text = 64'("for");
      4'd11:   kw_text = 64'("and");
      4'd12:   kw_text = 64'("or");
      4'd13:   kw_text = 64'("function");
      default: kw_text = 64'd0;
    endcase
  endfunction

  // character at position pos of keyword idx, valid for pos below its length
  function automatic logic [7:0] kw_char(input logic [3:0] idx, input logic [2:0] pos);
    logic [63:0] txt;
    logic [3:0]  sh;
    txt = kw_text(idx);
    sh = kw_len(idx) - 4'd1 - {1'b0, pos};
    kw_char = txt[{sh[2:0], 3'b000} +: 8];
  endfunction

endpackage

// File: hw/rtl/tdl_front.sv
// front end: lexer state machine, token tracking and classification
// depends on tdl_pkg
module tdl_front #(
  parameter int MAX_TOKEN_LENGTH = tdl_pkg::DEF_MAX_TOKEN_LENGTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  tdl_pkg::in_item_t item,
  output logic              rec_valid,
  output tdl_pkg::rec_t     rec
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);

  tdl_pkg::lex_state_t state_r, state_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [tdl_pkg::NUM_KW-1:0] cand_r, cand_nxt, cand_base;
  logic                alpha_r, alpha_nxt;
  logic [1:0]          dots_r, dots_nxt;
  logic [1:0]          spec_r, spec_nxt;

  tdl_pkg::col_t       col;
  logic [7:0]          c;
  logic                is_char, active, is_append, do_flush, flush_v, sym_v;
  logic                kw_found;
  logic [3:0]          kw_idx;
  logic [2:0]          flush_cls;
  logic [LEN_W+7:0]    len_wide;
  tdl_pkg::out_item_t  res_flush, res_sym;

  assign c       = item.character;
  assign col     = tdl_pkg::col_of(c);
  assign is_char = (item.kind == tdl_pkg::KIND_CHAR);
  assign active  = is_char && (state_r != tdl_pkg::ST_COMMENT);

  // next state
  always_comb begin
    state_nxt = state_r;
    if (is_char) begin
      if (state_r == tdl_pkg::ST_COMMENT) begin
        if (c == tdl_pkg::CH_BANG) begin
          state_nxt = tdl_pkg::ST_START;
        end
      end else begin
        state_nxt = tdl_pkg::next_state(state_r, col);
      end
    end
  end

  // token bookkeeping and results
  always_comb begin
    is_append = active && (state_nxt == tdl_pkg::ST_WORD || state_nxt == tdl_pkg::ST_NUM ||
                           state_nxt == tdl_pkg::ST_NUM_DOT);
    do_flush  = !is_char || (active && !is_append);
    flush_v   = do_flush && (len_r != '0);
    sym_v     = active && !is_append && (state_nxt != tdl_pkg::ST_COMMENT) &&
                (col == tdl_pkg::COL_OP || col == tdl_pkg::COL_SEP || col == tdl_pkg::COL_DOT);

    // lowest surviving keyword whose length equals the token length
    kw_found = 1'b0;
    kw_idx   = '0;
    for (int i = tdl_pkg::NUM_KW - 1; i >= 0; i--) begin
      if (cand_r[i] && len_r == LEN_W'(tdl_pkg::kw_len(4'(i)))) begin
        kw_found = 1'b1;
        kw_idx   = 4'(i);
      end
    end

    if (kw_found) begin
      flush_cls = tdl_pkg::CLS_KEYWORD;
    end else if (alpha_r) begin
      flush_cls = tdl_pkg::CLS_IDENT;
    end else if (dots_r >= 2'd2) begin
      flush_cls = tdl_pkg::CLS_INVALID;
    end else begin
      case (spec_r)
        tdl_pkg::SPEC_NONE: flush_cls = tdl_pkg::CLS_INT;
        tdl_pkg::SPEC_DOT:  flush_cls = tdl_pkg::CLS_FLOAT;
        default:            flush_cls = tdl_pkg::CLS_INVALID;
      endcase
    end

    len_wide = {8'd0, len_r};
    res_flush.token_class    = flush_cls;
    res_flush.keyword_number = kw_found ? kw_idx : 4'd0;
    res_flush.lexeme_length  = len_wide[7:0];
    res_flush.symbol         = 8'd0;
    res_flush.last_of_run    = !sym_v;

    res_sym.token_class    = (col == tdl_pkg::COL_OP) ? tdl_pkg::CLS_OP : tdl_pkg::CLS_SEP;
    res_sym.keyword_number = 4'd0;
    res_sym.lexeme_length  = 8'd1;
    res_sym.symbol         = c;
    res_sym.last_of_run    = 1'b1;

    rec_valid = step && (flush_v || sym_v);
    rec.two   = flush_v && sym_v;
    rec.r0    = flush_v ? res_flush : res_sym;
    rec.r1    = res_sym;

    // token registers
    len_nxt   = len_r;
    cand_nxt  = cand_r;
    alpha_nxt = alpha_r;
    dots_nxt  = dots_r;
    spec_nxt  = spec_r;
    cand_base = (len_r == '0) ? '1 : cand_r;
    if (do_flush) begin
      len_nxt   = '0;
      cand_nxt  = '1;
      alpha_nxt = 1'b0;
      dots_nxt  = 2'd0;
      spec_nxt  = tdl_pkg::SPEC_NONE;
    end else if (is_append) begin
      if (len_r == '0) begin
        alpha_nxt = tdl_pkg::is_letter(c);
      end
      for (int i = 0; i < tdl_pkg::NUM_KW; i++) begin
        // len_r below a keyword length implies it fits in three bits
        cand_nxt[i] = cand_base[i] && (len_r < LEN_W'(tdl_pkg::kw_len(4'(i)))) &&
                      (tdl_pkg::kw_char(4'(i), len_r[2:0]) == c);
      end
      if (c == tdl_pkg::CH_DOT) begin
        dots_nxt = (dots_r == 2'd2) ? 2'd2 : dots_r + 2'd1;
        spec_nxt = tdl_pkg::SPEC_DOT;
      end else if (c == tdl_pkg::CH_DOLLAR) begin
        spec_nxt = tdl_pkg::SPEC_DOLLAR;
      end
      if (len_r < LEN_W'(MAX_TOKEN_LENGTH)) begin
        len_nxt = len_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdl_pkg::ST_START;
      len_r   <= '0;
      cand_r  <= '1;
      alpha_r <= 1'b0;
      dots_r  <= 2'd0;
      spec_r  <= tdl_pkg::SPEC_NONE;
    end else if (step) begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cand_r  <= cand_nxt;
      alpha_r <= alpha_nxt;
      dots_r  <= dots_nxt;
      spec_r  <= spec_nxt;
    end
  end

endmodule

// File: hw/rtl/tdl_queue.sv
// short queue of result records between front and back end
// depends on tdl_pkg
module tdl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tdl_pkg::rec_t      push_rec,
  input  logic               pop,
  output tdl_pkg::q_status_t status,
  output tdl_pkg::rec_t      head
);

  localparam int PTR_W = (tdl_pkg::QDEPTH > 1) ? $clog2(tdl_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(tdl_pkg::QDEPTH + 1);

  tdl_pkg::rec_t    mem_r [tdl_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign status.avail = (cnt_r != '0);
  assign status.full  = (cnt_r == CNT_W'(tdl_pkg::QDEPTH));
  assign head         = mem_r[rd_ptr_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.avail;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(tdl_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(tdl_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// File: hw/rtl/tdl_back.sv
// back end: output register that hands out the results of a record one by one
// depends on tdl_pkg
module tdl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tdl_pkg::q_status_t q_status,
  input  tdl_pkg::rec_t      q_head,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output tdl_pkg::out_item_t out_item
);

  tdl_pkg::rec_t rec_r;
  logic          valid_r, valid_nxt;
  logic          idx_r, idx_nxt;
  logic          take, rec_done;

  assign take      = valid_r && out_pop;
  // record slot frees when empty or when its final result leaves
  assign rec_done  = !valid_r || (take && (idx_r || !rec_r.two));
  assign q_pop     = rec_done && q_status.avail;
  assign out_empty = !valid_r;
  assign out_item  = idx_r ? rec_r.r1 : rec_r.r0;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (rec_done) begin
      valid_nxt = q_status.avail;
      idx_nxt   = 1'b0;
    end else if (take) begin
      idx_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= q_head;
    end
  end

endmodule

// File: hw/rtl/table_driven_lexer_unit.sv
// top level of the table driven lexer: front end, record queue, back end
// depends on tdl_pkg, tdl_front, tdl_queue, tdl_back
//
//  channel | ports                    | handshake
//  --------+--------------------------+-----------------------------------
//  input   | in_item (kind,character) | taken when in_push && !in_full
//  result  | out_item (5 fields)      | taken when out_pop && !out_empty
//
// one input item per cycle enters the lexer state machine unless in_full is high;
// its one or two results land in a four-entry record queue and leave one per cycle
// through the output register while out_pop is high, each result held in the queue first
// the output port, one result per cycle, sets the sustained rate when items make two results
// in_full rises only when the record queue is full
// synchronous active-low reset returns the lexer to the start state with no token pending
module table_driven_lexer_unit #(
  parameter int MAX_TOKEN_LENGTH = tdl_pkg::DEF_MAX_TOKEN_LENGTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  tdl_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output tdl_pkg::out_item_t out_item
);

  tdl_pkg::q_status_t q_status;
  tdl_pkg::rec_t      front_rec, q_head;
  logic               step, front_valid, q_pop;

  assign in_full = q_status.full;
  assign step    = in_push && !q_status.full;

  tdl_front #(
    .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (in_item),
    .rec_valid(front_valid),
    .rec      (front_rec)
  );

  tdl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (front_valid),
    .push_rec(front_rec),
    .pop     (q_pop),
    .status  (q_status),
    .head    (q_head)
  );

  tdl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

endmodule

// File: hw/rtl/tdl_checker.sv
// port-level checks of the lexer result channel, bound to the top level
// depends on tdl_pkg and table_driven_lexer_unit_assert.svh
`include "table_driven_lexer_unit_assert.svh"

module tdl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input tdl_pkg::in_item_t  in_item,
  input logic               out_empty,
  input logic               out_pop,
  input tdl_pkg::out_item_t out_item
);

  logic is_sym;
  logic in_take;

  assign is_sym  = (out_item.token_class == tdl_pkg::CLS_OP) ||
                   (out_item.token_class == tdl_pkg::CLS_SEP);
  assign in_take = in_push && !in_full && (in_item.kind == tdl_pkg::KIND_CHAR);

  // waiting item holds until taken
  `TDL_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_item), "result changed while stalled")

  `TDL_ASSERT_NOW(a_cls_range, !out_empty, out_item.token_class <= tdl_pkg::CLS_SEP, "token class out of range")

  `TDL_ASSERT_NOW(a_kw_only, !out_empty && out_item.token_class != tdl_pkg::CLS_KEYWORD, out_item.keyword_number == 4'd0, "keyword number on non-keyword")

  `TDL_ASSERT_NOW(a_sym_len, !out_empty && is_sym, out_item.lexeme_length == 8'd1 && out_item.last_of_run, "operator or separator malformed")

  `TDL_ASSERT_NOW(a_tok_sym, !out_empty && !is_sym && in_take, out_item.symbol == 8'd0, "symbol set on word token")

endmodule

bind table_driven_lexer_unit tdl_checker u_tdl_checker (.*);

// File: tb/tb.sv
// testbench for table_driven_lexer_unit: streams characters and end-of-line items,
// predicts the tokens with its own lexer model and checks every popped result
// depends on tdl_pkg and the lexer rtl
`timescale 1ns / 100ps

module tb;

  localparam int MAX_LEN = tdl_pkg::DEF_MAX_TOKEN_LENGTH;
  localparam int RANDOM_ITEMS = 900;
  localparam int CALM_TAIL = 120;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_MAX = 10;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  tdl_pkg::in_item_t  in_item;
  logic               out_empty;
  logic               out_pop;
  tdl_pkg::out_item_t out_item;

  tdl_pkg::in_item_t  char_stream[$];
  tdl_pkg::out_item_t expected_tokens[$];
  tdl_pkg::in_item_t  taken;

  string kw_words[tdl_pkg::NUM_KW] = '{"int", "float", "bool", "if", "else", "then", "do",
                                       "while", "whileend", "doend", "for", "and", "or",
                                       "function"};
  string op_chars = "*+-=/><%";
  string sep_chars = "'(){}[],.:;";
  string odd_chars = "\"#&?@\\^_|~ ";

  // lexer model state
  tdl_pkg::lex_state_t        lex_now;
  int                         tok_len;
  logic [tdl_pkg::NUM_KW-1:0] kw_alive;
  logic                       tok_alpha;
  logic [1:0]                 dots;
  logic [1:0]                 special;

  int mismatches = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  logic timed_out = 1'b0;

  table_driven_lexer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic tdl_pkg::col_t char_column(input logic [7:0] c);
    int i;
    if (is_alpha(c)) return tdl_pkg::COL_LETTER;
    if ((c >= 8'h30 && c <= 8'h39) || c == tdl_pkg::CH_DOLLAR) return tdl_pkg::COL_DIGIT;
    if (c == tdl_pkg::CH_BANG) return tdl_pkg::COL_BANG;
    if (c == tdl_pkg::CH_DOT) return tdl_pkg::COL_DOT;
    for (i = 0; i < op_chars.len(); i++) begin
      if (op_chars[i] == c) return tdl_pkg::COL_OP;
    end
    for (i = 0; i < sep_chars.len(); i++) begin
      if (sep_chars[i] == c) return tdl_pkg::COL_SEP;
    end
    return tdl_pkg::COL_OTHER;
  endfunction

  function automatic tdl_pkg::lex_state_t lexer_next(input tdl_pkg::lex_state_t s,
                                                     input tdl_pkg::col_t col);
    case (s)
      tdl_pkg::ST_START: begin
        if (col == tdl_pkg::COL_LETTER) return tdl_pkg::ST_WORD;
        if (col == tdl_pkg::COL_DIGIT) return tdl_pkg::ST_NUM;
        if (col == tdl_pkg::COL_BANG) return tdl_pkg::ST_COMMENT;
      end
      tdl_pkg::ST_WORD: begin
        if (col == tdl_pkg::COL_LETTER || col == tdl_pkg::COL_DIGIT) return tdl_pkg::ST_WORD;
        if (col == tdl_pkg::COL_BANG) return tdl_pkg::ST_COMMENT;
      end
      tdl_pkg::ST_NUM, tdl_pkg::ST_NUM_DOT: begin
        if (col == tdl_pkg::COL_LETTER) return tdl_pkg::ST_BAD;
        if (col == tdl_pkg::COL_DIGIT) return s;
        if (col == tdl_pkg::COL_DOT) return tdl_pkg::ST_NUM_DOT;
        if (col == tdl_pkg::COL_BANG) return tdl_pkg::ST_COMMENT;
      end
      tdl_pkg::ST_COMMENT: begin
        return (col == tdl_pkg::COL_BANG) ? tdl_pkg::ST_START : tdl_pkg::ST_COMMENT;
      end
      default: begin
      end
    endcase
    return tdl_pkg::ST_START;
  endfunction

  task automatic clear_token();
    tok_len = 0;
    kw_alive = '1;
    tok_alpha = 1'b0;
    dots = 2'd0;
    special = tdl_pkg::SPEC_NONE;
  endtask

  task automatic push_token(input logic [2:0] cls, input logic [3:0] kw,
                            input logic [7:0] len, input logic [7:0] sym);
    tdl_pkg::out_item_t t;
    t.token_class = cls;
    t.keyword_number = kw;
    t.lexeme_length = len;
    t.symbol = sym;
    t.last_of_run = 1'b0;
    expected_tokens.insert(expected_tokens.size(), t);
  endtask

  task automatic grow_token(input logic [7:0] c);
    int i;
    int pos;
    pos = tok_len;
    if (pos == 0) begin
      tok_alpha = is_alpha(c);
      kw_alive = '1;
    end
    for (i = 0; i < tdl_pkg::NUM_KW; i++) begin
      if (pos >= kw_words[i].len() || kw_words[i][pos] != c) kw_alive[i] = 1'b0;
    end
    if (c == tdl_pkg::CH_DOT) begin
      if (dots < 2'd2) dots = dots + 2'd1;
      special = tdl_pkg::SPEC_DOT;
    end else if (c == tdl_pkg::CH_DOLLAR) begin
      special = tdl_pkg::SPEC_DOLLAR;
    end
    if (tok_len < MAX_LEN) tok_len++;
  endtask

  task automatic finish_token();
    int i;
    logic found;
    logic [3:0] kw;
    logic [2:0] cls;
    found = 1'b0;
    kw = 4'd0;
    if (tok_len != 0) begin
      // first surviving keyword of exactly this length wins
      for (i = 0; i < tdl_pkg::NUM_KW; i++) begin
        if (!found && kw_alive[i] && kw_words[i].len() == tok_len) begin
          found = 1'b1;
          kw = 4'(i);
        end
      end
      if (found) cls = tdl_pkg::CLS_KEYWORD;
      else if (tok_alpha) cls = tdl_pkg::CLS_IDENT;
      else if (dots >= 2'd2) cls = tdl_pkg::CLS_INVALID;
      else if (special == tdl_pkg::SPEC_NONE) cls = tdl_pkg::CLS_INT;
      else if (special == tdl_pkg::SPEC_DOT) cls = tdl_pkg::CLS_FLOAT;
      else cls = tdl_pkg::CLS_INVALID;
      push_token(cls, kw, 8'(tok_len), 8'h00);
    end
    clear_token();
  endtask

  task automatic predict_tokens(input tdl_pkg::in_item_t it);
    logic [7:0] c;
    tdl_pkg::col_t col;
    int first;
    c = it.character;
    first = expected_tokens.size();
    if (it.kind == tdl_pkg::KIND_EOL) begin
      finish_token();
    end else if (lex_now == tdl_pkg::ST_COMMENT) begin
      if (c == tdl_pkg::CH_BANG) lex_now = tdl_pkg::ST_START;
    end else begin
      col = char_column(c);
      lex_now = lexer_next(lex_now, col);
      if (lex_now == tdl_pkg::ST_WORD || lex_now == tdl_pkg::ST_NUM ||
          lex_now == tdl_pkg::ST_NUM_DOT) begin
        grow_token(c);
      end else begin
        finish_token();
        if (lex_now != tdl_pkg::ST_COMMENT) begin
          if (col == tdl_pkg::COL_OP) begin
            push_token(tdl_pkg::CLS_OP, 4'd0, 8'd1, c);
          end else if (col == tdl_pkg::COL_SEP || col == tdl_pkg::COL_DOT) begin
            push_token(tdl_pkg::CLS_SEP, 4'd0, 8'd1, c);
          end
        end
      end
    end
    if (expected_tokens.size() > first) begin
      expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
    end
  endtask

  task automatic check_token(input tdl_pkg::out_item_t got);
    tdl_pkg::out_item_t want;
    if (expected_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected token: class %0d kw %0d len %0d sym %h last %0b",
                 got.token_class, got.keyword_number, got.lexeme_length, got.symbol,
                 got.last_of_run);
    end else begin
      want = expected_tokens.pop_front();
      if (want.token_class !== got.token_class || want.keyword_number !== got.keyword_number ||
          want.lexeme_length !== got.lexeme_length || want.symbol !== got.symbol ||
          want.last_of_run !== got.last_of_run) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("token mismatch: expected class %0d kw %0d len %0d sym %h last %0b, %s",
                   want.token_class, want.keyword_number, want.lexeme_length, want.symbol,
                   want.last_of_run,
                   $sformatf("got class %0d kw %0d len %0d sym %h last %0b",
                             got.token_class, got.keyword_number, got.lexeme_length,
                             got.symbol, got.last_of_run));
      end
    end
  endtask

  // stimulus helpers
  task automatic add_char(input logic [7:0] c);
    tdl_pkg::in_item_t it;
    it.kind = tdl_pkg::KIND_CHAR;
    it.character = c;
    char_stream.insert(char_stream.size(), it);
  endtask

  task automatic add_eol(input logic [7:0] c);
    tdl_pkg::in_item_t it;
    it.kind = tdl_pkg::KIND_EOL;
    it.character = c;
    char_stream.insert(char_stream.size(), it);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 25));
    return ($urandom_range(0, 1) != 0) ? 8'h41 + c : 8'h61 + c;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_odd();
    case ($urandom_range(0, 2))
      0: return odd_chars[$urandom_range(0, odd_chars.len() - 1)];
      1: return 8'($urandom_range(0, 31));
      default: return 8'($urandom_range(127, 255));
    endcase
  endfunction

  task automatic add_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) add_char(rand_digit());
  endtask

  // one well-formed or broken lexeme followed by a delimiter or by nothing
  task automatic add_phrase();
    string w;
    int i;
    int k;
    int n;
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1: begin
        w = kw_words[$urandom_range(0, tdl_pkg::NUM_KW - 1)];
        k = $urandom_range(0, 7);
        n = (k == 1) ? w.len() - 1 : w.len();
        for (i = 0; i < n; i++) begin
          c = w[i];
          if (i == 0 && k == 0) c = c - 8'h20;
          add_char(c);
        end
        if (k == 2) add_char(rand_letter());
        if (k == 3) add_char(rand_digit());
      end
      2: begin
        add_char(rand_letter());
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 7))
            0: add_char(tdl_pkg::CH_DOLLAR);
            1, 2: add_char(rand_digit());
            default: add_char(rand_letter());
          endcase
        end
      end
      3: add_digits(1, 6);
      4: begin
        add_digits(1, 3);
        add_char(tdl_pkg::CH_DOT);
        add_digits(0, 3);
      end
      5: begin
        add_digits(1, 2);
        repeat ($urandom_range(2, 4)) begin
          add_char(tdl_pkg::CH_DOT);
          add_digits(0, 2);
        end
      end
      6: begin
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 5))
            0, 1: add_char(tdl_pkg::CH_DOLLAR);
            2: add_char(tdl_pkg::CH_DOT);
            default: add_char(rand_digit());
          endcase
        end
      end
      7: begin
        // letter right after a number, then whatever follows
        add_digits(1, 3);
        if ($urandom_range(0, 1) != 0) begin
          add_char(tdl_pkg::CH_DOT);
          add_digits(0, 2);
        end
        add_char(rand_letter());
        add_char(8'($urandom_range(0, 255)));
      end
      8: begin
        add_char(tdl_pkg::CH_BANG);
        repeat ($urandom_range(0, 10)) begin
          if ($urandom_range(0, 4) == 0) begin
            add_eol(8'($urandom_range(0, 255)));
          end else begin
            c = 8'($urandom_range(0, 255));
            add_char((c == tdl_pkg::CH_BANG) ? 8'h20 : c);
          end
        end
        if ($urandom_range(0, 7) != 0) add_char(tdl_pkg::CH_BANG);
      end
      9: begin
        // end of line inside a number keeps the number state
        add_digits(1, 3);
        add_eol(8'($urandom_range(0, 255)));
        add_digits(0, 3);
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 7) == 0) add_eol(8'($urandom_range(0, 255)));
          else add_char(8'($urandom_range(0, 255)));
        end
      end
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: add_char(8'h20);
      3, 4: add_char(op_chars[$urandom_range(0, op_chars.len() - 1)]);
      5, 6: add_char(sep_chars[$urandom_range(0, sep_chars.len() - 1)]);
      7: add_eol(8'($urandom_range(0, 255)));
      8: add_char(rand_odd());
      default: begin
      end
    endcase
  endtask

  // driver: one item per push, taken when the block is not full
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        taken = char_stream.pop_front();
        predict_tokens(taken);
      end
      if (in_gap != 0) begin
        in_gap = in_gap - 1;
      end else if (char_stream.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 15);
      end
      if (in_gap == 0 && char_stream.size() != 0) begin
        in_item <= char_stream[0];
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor: pops results with random stalls and checks them in order
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_token(out_item);
      if (out_gap != 0) begin
        out_gap = out_gap - 1;
      end else if (char_stream.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 15);
      end
      out_pop <= (out_gap == 0);
    end
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) timed_out <= 1'b1;
    end
  end

  initial begin
    int phrase_no;
    int base;
    rst_n = 1'b0;
    in_push = 1'b0;
    out_pop = 1'b0;
    in_item = '0;
    lex_now = tdl_pkg::ST_START;
    clear_token();

    // directed: keyword, operator, two-dot number, float, dropped letter,
    // dollar number, unclassed byte, comment across a line end, word state after eol
    add_text("do+1.5.6(3.5,9xy*$");
    add_char(8'hFF);
    add_text("!q");
    add_eol(8'h00);
    add_text("!a");
    add_eol(8'hFF);
    add_char(8'h35);
    add_char(8'h00);

    base = char_stream.size();
    phrase_no = 0;
    while (char_stream.size() - base < RANDOM_ITEMS) begin
      phrase_no++;
      if (phrase_no == 60) begin
        // tokens near and past the length limit
        add_char(rand_letter());
        repeat ($urandom_range(250, 300)) add_char(rand_letter());
        add_char(8'h20);
        add_digits(256, 270);
        add_char(8'h3B);
      end
      add_phrase();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (!timed_out && (char_stream.size() != 0 || expected_tokens.size() != 0))
      @(posedge clk);
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk);
    if (!timed_out && mismatches == 0 && expected_tokens.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tdl_pkg.sv
hw/rtl/tdl_front.sv
hw/rtl/tdl_queue.sv
hw/rtl/tdl_back.sv
hw/rtl/table_driven_lexer_unit.sv
hw/rtl/tdl_checker.sv
tb/tb.sv
